### rtl/hrp_pkg.sv
package hrp_pkg;

  localparam int AddrWidth = 17;

  localparam logic [7:0] CharColon = 8'd58;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharCr    = 8'd13;

  localparam logic [7:0] RecData = 8'h00;
  localparam logic [7:0] RecEof  = 8'h01;

  typedef enum logic {
    KindData = 1'b0,
    KindEnd  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [AddrWidth-1:0] byte_address;
    logic [7:0]           data_byte;
  } result_t;

endpackage

### rtl/hrp_core.sv
module hrp_core #(
  parameter int MAX_RECORD_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  logic [7:0]       char_in,
  output hrp_pkg::result_t res
);

  localparam logic [5:0] PosMax    = 6'd63;
  localparam logic [5:0] PosLength = 6'd2;
  localparam logic [5:0] PosAddrHi = 6'd4;
  localparam logic [5:0] PosAddrLo = 6'd6;
  localparam logic [5:0] PosType   = 6'd8;
  localparam logic [5:0] PosData   = 6'd10;
  localparam logic [7:0] MaxBytes  = 8'(MAX_RECORD_BYTES);

  logic [5:0]  char_position, char_position_next;
  logic        line_active, line_active_next;
  logic [3:0]  pending_nibble, pending_nibble_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  record_type, record_type_next;
  logic        finished, finished_next;

  logic [3:0]  nib;
  logic [7:0]  pair_byte;
  logic [5:0]  pos_off;
  logic [4:0]  idx;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    begin
      n = 4'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
        n = 4'(c - 8'd48);
      end else if (c >= 8'd97 && c <= 8'd102) begin
        n = 4'(c - 8'd87);
      end else if (c >= 8'd65 && c <= 8'd70) begin
        n = 4'(c - 8'd55);
      end
      return n;
    end
  endfunction

  assign nib       = nibble_of(char_in);
  assign pair_byte = {pending_nibble, nib};
  assign pos_off   = char_position - PosData;
  assign idx       = pos_off[5:1];

  always_comb begin
    char_position_next  = char_position;
    line_active_next    = line_active;
    pending_nibble_next = pending_nibble;
    record_length_next  = record_length;
    record_address_next = record_address;
    record_type_next    = record_type;
    finished_next       = finished;
    res                 = '0;
    if (step_en && !finished) begin
      if (char_in == hrp_pkg::CharCr || char_in == hrp_pkg::CharLf) begin
        line_active_next   = 1'b0;
        char_position_next = 6'd0;
      end else if (!line_active) begin
        if (char_position == 6'd0) begin
          line_active_next   = (char_in == hrp_pkg::CharColon);
          char_position_next = 6'd1;
        end
      end else begin
        if (char_position[0]) begin
          pending_nibble_next = nib;
        end else begin
          case (char_position)
            PosLength: record_length_next = pair_byte;
            PosAddrHi: record_address_next = {pair_byte, record_address[7:0]};
            PosAddrLo: record_address_next = {record_address[15:8], pair_byte};
            PosType: begin
              record_type_next = pair_byte;
              if (pair_byte == hrp_pkg::RecEof) begin
                finished_next = 1'b1;
                res.valid     = 1'b1;
                res.kind      = hrp_pkg::KindEnd;
              end
            end
            default: begin
              if (char_position >= PosData && record_type == hrp_pkg::RecData &&
                  {3'b000, idx} < record_length && {3'b000, idx} < MaxBytes) begin
                res.valid        = 1'b1;
                res.kind         = hrp_pkg::KindData;
                res.byte_address = {1'b0, record_address} + hrp_pkg::AddrWidth'(idx);
                res.data_byte    = pair_byte;
              end
            end
          endcase
        end
        if (char_position != PosMax) begin
          char_position_next = char_position + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= '0;
      line_active    <= 1'b0;
      pending_nibble <= '0;
      record_length  <= '0;
      record_address <= '0;
      record_type    <= '0;
      finished       <= 1'b0;
    end else begin
      char_position  <= char_position_next;
      line_active    <= line_active_next;
      pending_nibble <= pending_nibble_next;
      record_length  <= record_length_next;
      record_address <= record_address_next;
      record_type    <= record_type_next;
      finished       <= finished_next;
    end
  end

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("end state left without reset");

  a_result_needs_step: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (step_en && !finished))
    else $error("result without a live character");

  a_end_sets_finished: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == hrp_pkg::KindEnd) |=> finished)
    else $error("end record did not stop the parser");

  a_idle_line_position: assert property (@(posedge clk) disable iff (rst)
    !line_active |-> char_position <= 6'd1)
    else $error("position advanced on an inactive line");

endmodule

### rtl/hex_record_parser.sv
// Intel HEX record parser: takes one text character per transfer and returns one
// transfer per decoded data byte (kind 0, with record address plus byte index)
// and one end transfer (kind 1) for the end-of-file record, after which input is
// swallowed until reset. A character is accepted every cycle while results are
// taken; a result leaves through an input register and a result register, and
// the record state update keeps pace with that rate. Non-hex digits read as zero
// and the checksum is not verified.
module hex_record_parser #(
  parameter int MAX_RECORD_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          char_valid,
  output logic                          char_stall,
  input  logic [7:0]                    char_code,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          kind,
  output logic [hrp_pkg::AddrWidth-1:0] byte_address,
  output logic [7:0]                    data_byte
);

  logic             s1_valid;
  logic [7:0]       s1_char;
  logic             out_free;
  logic             s1_adv;
  hrp_pkg::result_t res;

  assign out_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_free;
  assign char_stall = s1_valid && !out_free;

  hrp_core #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step_en(s1_adv),
    .char_in(s1_char),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= res.valid;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      s1_char <= char_code;
    end
    if (s1_adv && res.valid) begin
      kind         <= res.kind;
      byte_address <= res.byte_address;
      data_byte    <= res.data_byte;
    end
  end

endmodule
